[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, status codes and defaults for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int PRIO_W           = 8;
    localparam int STATUS_W         = 2;
    localparam int OCC_W            = 5;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJ_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJ_EMPTY  = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t entry;
    } cell_cmd_t;

endpackage

[design/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue held in a chain of sorted cells
//
//   channel   direction   transfer                payload
//   in        input       in_valid & in_ready     kind, item_value, item_priority
//   out       output      out_valid & out_ready   status, out_value, out_priority,
//                                                  occupancy, is_full, is_empty
//
// one item per cycle: every cell compares and shifts locally in the cycle of
// the input transfer, and the result lands in the output register
// a new item is taken while the result register is empty or being drained
// reset clears the count and the output valid; cell contents need no reset
// a stalled output holds the input side off until the result is taken
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic signed [spq_pkg::VALUE_W-1:0]   item_value,
    input  logic        [spq_pkg::PRIO_W-1:0]    item_priority,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [spq_pkg::STATUS_W-1:0]  status,
    output logic signed [spq_pkg::VALUE_W-1:0]   out_value,
    output logic        [spq_pkg::PRIO_W-1:0]    out_priority,
    output logic        [spq_pkg::OCC_W-1:0]     occupancy,
    output logic                                 is_full,
    output logic                                 is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [spq_pkg::STATUS_W-1:0]       status_reg;
    logic [spq_pkg::STATUS_W-1:0]       status_next;
    spq_pkg::entry_t                    res_reg;
    spq_pkg::entry_t                    res_next;
    logic [CNT_W-1:0]                   occ_reg;

    logic                               xfer;
    logic                               full;
    logic                               empty;
    spq_pkg::cell_cmd_t                 cmd;
    spq_pkg::entry_t                    cell_entry [CAPACITY];
    logic                               cell_ins   [CAPACITY];
    logic [CNT_W+spq_pkg::OCC_W-1:0]    occ_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign xfer     = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;

    assign cmd.enq            = xfer && (kind == spq_pkg::KIND_ENQ) && !full;
    assign cmd.deq            = xfer && (kind == spq_pkg::KIND_DEQ) && !empty;
    assign cmd.entry.value    = item_value;
    assign cmd.entry.prio     = item_priority;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        spq_pkg::entry_t left_e;
        spq_pkg::entry_t right_e;
        logic            left_i;

        if (k == 0)
        begin : g_first
            assign left_e = cell_entry[0];
            assign left_i = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[k-1];
            assign left_i = cell_ins[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_e = cell_entry[k];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[k+1];
        end

        spq_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_entry  (left_e),
            .left_ins    (left_i),
            .right_entry (right_e),
            .entry       (cell_entry[k]),
            .ins         (cell_ins[k])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (xfer)
        begin
            out_valid_next = 1'b1;
            res_next       = '0;
            unique case (kind)
                spq_pkg::KIND_ENQ:
                begin
                    if (full)
                    begin
                        status_next = spq_pkg::ST_REJ_FULL;
                    end
                    else
                    begin
                        status_next = spq_pkg::ST_ENQUEUED;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                spq_pkg::KIND_DEQ:
                begin
                    if (empty)
                    begin
                        status_next = spq_pkg::ST_REJ_EMPTY;
                    end
                    else
                    begin
                        status_next = spq_pkg::ST_DEQUEUED;
                        res_next    = cell_entry[0];
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
        if (xfer)
        begin
            occ_reg <= count_next;
        end
    end

    assign occ_wide     = {{spq_pkg::OCC_W{1'b0}}, occ_reg};
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = res_reg.value;
    assign out_priority = res_reg.prio;
    assign occupancy    = occ_wide[spq_pkg::OCC_W-1:0];
    assign is_full      = occ_reg == CNT_W'(CAPACITY);
    assign is_empty     = occ_reg == '0;

endmodule

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, loads the new entry, or takes a neighbor
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                  clk,
    input  spq_pkg::cell_cmd_t    cmd,
    input  logic [CNT_W-1:0]      count,
    input  spq_pkg::entry_t       left_entry,
    input  logic                  left_ins,
    input  spq_pkg::entry_t       right_entry,
    output spq_pkg::entry_t       entry,
    output logic                  ins
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occupied;

    assign occupied = CNT_W'(INDEX) < count;
    assign ins      = !occupied || (entry_reg.prio > cmd.entry.prio);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.enq && ins)
        begin
            entry_next = left_ins ? left_entry : cmd.entry;
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
